// ----- design/next_fit_slot_allocator_top_assert.svh -----
// Assertion macros for the next-fit slot allocator.
`ifndef NEXT_FIT_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define NEXT_FIT_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define NFSA_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define NFSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NFSA_ASSERT_RST(lbl, clk, rstn, prop, msg)
`define NFSA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- design/nfsa_pkg.sv -----
// Shared types and constants for the next-fit slot allocator.
`default_nettype none

package nfsa_pkg;

    // Field widths of the input and result beats.
    localparam int KIND_W   = 1;
    localparam int TYPE_W   = 4;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 7;

    // The free search works on groups of this many slots.
    localparam int GRP_W    = 16;
    localparam int GRP_BITS = 4;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_TAKEN = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic commit;
    } nfsa_cmd_t;

endpackage

`default_nettype wire

// ----- design/nfsa_ctrl.sv -----
// Controller state machine for the next-fit slot allocator.
`default_nettype none

module nfsa_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output nfsa_pkg::nfsa_cmd_t    cmd
);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_COMMIT = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                // The result register must be empty or emptying this cycle.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- design/nfsa_scan.sv -----
// Registered per-group free-slot summary for the next-fit search.
`default_nettype none

module nfsa_scan #(
    parameter  int SLOTS = 64,
    localparam int IDXW  = $clog2(SLOTS),
    localparam int GW    = nfsa_pkg::GRP_W,
    localparam int GB    = nfsa_pkg::GRP_BITS,
    localparam int GROUPS = (SLOTS + GW - 1) / GW,
    localparam int GSW   = (GROUPS > 1) ? $clog2(GROUPS) : 1,
    localparam int PW    = GSW + GB,
    localparam int NP    = GROUPS * GW
) (
    input  wire logic                         clk,
    input  wire logic [SLOTS-1:0]             occ,
    input  wire logic [IDXW-1:0]              ptr,
    output logic      [GROUPS-1:0]            grp_any,
    output logic      [GROUPS-1:0][GB-1:0]    grp_first,
    output logic                              hi_any,
    output logic      [GB-1:0]                hi_first,
    output logic      [GSW-1:0]               ptr_grp
);

    logic [NP-1:0]              free_pad;
    logic [PW-1:0]              ptr_wide;
    logic [GSW-1:0]             pg;
    logic [GB-1:0]              po;
    logic [GW-1:0]              grp_bits;
    logic [GW-1:0]              hi_bits;
    logic [GROUPS-1:0]          any_c;
    logic [GROUPS-1:0][GB-1:0]  first_c;
    logic [GB-1:0]              hi_first_c;

    // Slots past the end of the table pad the last group and never look free.
    for (genvar i = 0; i < NP; i++)
    begin : g_pad
        if (i < SLOTS)
        begin : g_in
            assign free_pad[i] = ~occ[i];
        end
        else
        begin : g_out
            assign free_pad[i] = 1'b0;
        end
    end

    assign ptr_wide = PW'(ptr);
    assign pg       = ptr_wide[PW-1:GB];
    assign po       = ptr_wide[GB-1:0];
    assign grp_bits = free_pad[int'(pg)*GW +: GW];

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            any_c[g]   = |free_pad[g*GW +: GW];
            first_c[g] = '0;
            for (int b = GW - 1; b >= 0; b--)
            begin
                if (free_pad[g*GW + b])
                begin
                    first_c[g] = GB'(b);
                end
            end
        end
        hi_first_c = '0;
        for (int b = GW - 1; b >= 0; b--)
        begin
            hi_bits[b] = grp_bits[b] && (GB'(b) >= po);
            if (hi_bits[b])
            begin
                hi_first_c = GB'(b);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        grp_any   <= any_c;
        grp_first <= first_c;
        hi_any    <= |hi_bits;
        hi_first  <= hi_first_c;
        ptr_grp   <= pg;
    end

endmodule

`default_nettype wire

// ----- design/nfsa_dp.sv -----
// Datapath of the next-fit slot allocator: occupancy, pointer, count, result.
`default_nettype none

module nfsa_dp #(
    parameter  int SLOTS    = 64,
    parameter  int TAG_BITS = 4,
    localparam int IDXW     = $clog2(SLOTS),
    localparam int CNTW     = $clog2(SLOTS + 1),
    localparam int GB       = nfsa_pkg::GRP_BITS,
    localparam int GROUPS   = (SLOTS + nfsa_pkg::GRP_W - 1) / nfsa_pkg::GRP_W,
    localparam int GSW      = (GROUPS > 1) ? $clog2(GROUPS) : 1,
    localparam int PW       = GSW + GB,
    localparam int TB       = (TAG_BITS < nfsa_pkg::TYPE_W) ? TAG_BITS : nfsa_pkg::TYPE_W,
    localparam int CW       = (CNTW > nfsa_pkg::INDEX_W) ? CNTW : nfsa_pkg::INDEX_W,
    localparam int SW       = (IDXW > nfsa_pkg::SLOT_W) ? IDXW : nfsa_pkg::SLOT_W,
    localparam int LW       = (CNTW > nfsa_pkg::COUNT_W) ? CNTW : nfsa_pkg::COUNT_W
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire nfsa_pkg::nfsa_cmd_t               cmd,
    input  wire logic [nfsa_pkg::KIND_W-1:0]       kind,
    input  wire logic [nfsa_pkg::TYPE_W-1:0]       slot_type,
    input  wire logic [nfsa_pkg::INDEX_W-1:0]      slot_index,
    output logic      [nfsa_pkg::STATUS_W-1:0]     status,
    output logic      [nfsa_pkg::SLOT_W-1:0]       slot,
    output logic      [nfsa_pkg::COUNT_W-1:0]      live_count
);

    logic [SLOTS-1:0]                occ_reg;
    logic [SLOTS-1:0]                occ_next;
    logic [IDXW-1:0]                 ptr_reg;
    logic [IDXW-1:0]                 ptr_next;
    logic [CNTW-1:0]                 cnt_reg;
    logic [CNTW-1:0]                 cnt_next;

    logic [nfsa_pkg::KIND_W-1:0]     kind_reg;
    logic                            type_ok_reg;
    logic [nfsa_pkg::INDEX_W-1:0]    idx_reg;

    logic [nfsa_pkg::STATUS_W-1:0]   status_reg;
    logic [nfsa_pkg::SLOT_W-1:0]     slot_reg;
    logic [nfsa_pkg::COUNT_W-1:0]    live_reg;

    logic [GROUPS-1:0]               grp_any;
    logic [GROUPS-1:0][GB-1:0]       grp_first;
    logic                            hi_any;
    logic [GB-1:0]                   hi_first;
    logic [GSW-1:0]                  ptr_grp;

    logic [GROUPS-1:0]               upper;
    logic [GSW-1:0]                  sel_up;
    logic [GSW-1:0]                  sel_any;
    logic [PW-1:0]                   alloc_pos;
    logic [IDXW-1:0]                 pos_idx;
    logic                            full;
    logic [CW-1:0]                   idx_ext;
    logic [IDXW-1:0]                 fidx;
    logic                            free_ok;
    logic [nfsa_pkg::STATUS_W-1:0]   status_c;
    logic [IDXW-1:0]                 slot_num_c;
    logic [SW-1:0]                   slot_wide;
    logic [LW-1:0]                   cnt_wide;

    nfsa_scan #(
        .SLOTS     (SLOTS)
    ) u_scan (
        .clk       (clk),
        .occ       (occ_reg),
        .ptr       (ptr_reg),
        .grp_any   (grp_any),
        .grp_first (grp_first),
        .hi_any    (hi_any),
        .hi_first  (hi_first),
        .ptr_grp   (ptr_grp)
    );

    // Rotating pick: pointer group at or after the pointer, then later groups,
    // then wrap around to the lowest group holding a free slot.
    always_comb
    begin
        upper   = '0;
        sel_up  = '0;
        sel_any = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            upper[g] = grp_any[g] && (GSW'(g) > ptr_grp);
        end
        for (int g = GROUPS - 1; g >= 0; g--)
        begin
            if (upper[g])
            begin
                sel_up = GSW'(g);
            end
            if (grp_any[g])
            begin
                sel_any = GSW'(g);
            end
        end
        if (hi_any)
        begin
            alloc_pos = {ptr_grp, hi_first};
        end
        else if (|upper)
        begin
            alloc_pos = {sel_up, grp_first[sel_up]};
        end
        else
        begin
            alloc_pos = {sel_any, grp_first[sel_any]};
        end
    end

    assign full    = !hi_any && (grp_any == '0);
    assign pos_idx = alloc_pos[IDXW-1:0];
    assign idx_ext = CW'(idx_reg);
    assign fidx    = idx_ext[IDXW-1:0];
    assign free_ok = (idx_ext < CW'(SLOTS)) && occ_reg[fidx];

    always_comb
    begin
        occ_next   = occ_reg;
        ptr_next   = ptr_reg;
        cnt_next   = cnt_reg;
        status_c   = nfsa_pkg::ST_NOT_TAKEN;
        slot_num_c = '0;
        if (kind_reg == nfsa_pkg::KIND_ALLOC)
        begin
            if (!type_ok_reg)
            begin
                status_c = nfsa_pkg::ST_NOT_TAKEN;
            end
            else if (full)
            begin
                status_c = nfsa_pkg::ST_FULL;
            end
            else
            begin
                occ_next[pos_idx] = 1'b1;
                cnt_next          = cnt_reg + 1'b1;
                ptr_next          = (pos_idx == IDXW'(SLOTS - 1)) ? '0 : pos_idx + 1'b1;
                status_c          = nfsa_pkg::ST_DONE;
                slot_num_c        = pos_idx;
            end
        end
        else if (free_ok)
        begin
            occ_next[fidx] = 1'b0;
            ptr_next       = fidx;
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - 1'b1;
            end
            status_c   = nfsa_pkg::ST_DONE;
            slot_num_c = fidx;
        end
    end

    assign slot_wide = SW'(slot_num_c);
    assign cnt_wide  = LW'(cnt_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
            ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.commit)
        begin
            occ_reg <= occ_next;
            ptr_reg <= ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg    <= kind;
            type_ok_reg <= |slot_type[TB-1:0];
            idx_reg     <= slot_index;
        end
        if (cmd.commit)
        begin
            status_reg <= status_c;
            slot_reg   <= slot_wide[nfsa_pkg::SLOT_W-1:0];
            live_reg   <= cnt_wide[nfsa_pkg::COUNT_W-1:0];
        end
    end

    assign status     = status_reg;
    assign slot       = slot_reg;
    assign live_count = live_reg;

endmodule

`default_nettype wire

// ----- design/next_fit_slot_allocator_top.sv -----
// Top level of the next-fit slot allocator.
// A result beat is offered after its input beat is latched and then committed; the
// commit waits while an earlier result beat is pending. Items are handled one at a time:
// the registered group scan of the occupancy bitmap, then the rotating pick and commit.
// Reset: rst_n clears the occupancy bitmap, search pointer and live count at once;
// no clearing pass is needed and an input beat can be taken right after reset.
`default_nettype none
`include "next_fit_slot_allocator_top_assert.svh"

module next_fit_slot_allocator_top #(
    parameter int SLOTS    = 64,
    parameter int TAG_BITS = 4
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [nfsa_pkg::KIND_W-1:0]       kind,
    input  wire logic [nfsa_pkg::TYPE_W-1:0]       slot_type,
    input  wire logic [nfsa_pkg::INDEX_W-1:0]      slot_index,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [nfsa_pkg::STATUS_W-1:0]     status,
    output logic      [nfsa_pkg::SLOT_W-1:0]       slot,
    output logic      [nfsa_pkg::COUNT_W-1:0]      live_count
);

    // Commands from the controller. A load latches an accepted input beat; a
    // commit applies the item to the table and fills the result register.
    nfsa_pkg::nfsa_cmd_t cmd;

    // The controller alternates between taking a beat and committing it. It
    // holds the commit while an earlier result beat still waits downstream,
    // but it accepts a new input beat as soon as the commit is done, so a
    // pending result never blocks the next item from entering.
    nfsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // The datapath keeps one occupancy bit per slot. Only whether a tag is
    // zero can ever be observed, so a set bit stands for a nonzero tag. The
    // bitmap is summarized per group of slots into registers every cycle;
    // the commit cycle then picks the first free slot at or after the search
    // pointer, wrapping to slot zero, from that summary.
    nfsa_dp #(
        .SLOTS      (SLOTS),
        .TAG_BITS   (TAG_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .kind       (kind),
        .slot_type  (slot_type),
        .slot_index (slot_index),
        .status     (status),
        .slot       (slot),
        .live_count (live_count)
    );

    // A commit never overwrites a result beat that has not been taken.
    `NFSA_ASSERT_RST(a_commit_room, clk, rst_n, cmd.commit |-> (!out_valid || out_ready), "commit while result register busy")

    // A new result beat appears only right after a commit.
    `NFSA_ASSERT_RST(a_valid_from_commit, clk, rst_n, $rose(out_valid) |-> $past(cmd.commit), "result beat without commit")

    // Once a beat is taken, no second one is taken before its commit.
    `NFSA_ASSERT_RST(a_one_in_flight, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "second beat accepted before commit")

    // Refused or failed items report slot zero.
    `NFSA_ASSERT_RST(a_slot_zero, clk, rst_n, (out_valid && (status != nfsa_pkg::ST_DONE)) |-> (slot == '0), "nonzero slot on refused item")

    // Taking a beat and committing never happen in the same cycle.
    `NFSA_ASSERT_ALWAYS(a_load_commit_apart, clk, !(cmd.load && cmd.commit), "load and commit together")

endmodule

`default_nettype wire
